/* hdl/mss_pkg.sv */
package mss_pkg;

  // store geometry
  localparam int NUM_STACKS  = 4;
  localparam int NUM_ENTRIES = 64;
  localparam int VALUE_WIDTH = 32;

  localparam int IDX_W   = $clog2(NUM_ENTRIES);
  localparam int LINK_W  = $clog2(NUM_ENTRIES + 1);
  localparam int SIDX_W  = 2;
  localparam int FIELD_W = 32;

  // null link is the index one past the last entry
  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(NUM_ENTRIES);

  // operation codes
  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_POP  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_BUSY
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;  // latch the request and start the entry reads
    logic commit;  // update the lists and load the result register
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_full;  // result register holds an untaken transfer
  } dp_stat_t;

  // low value bits of the sign-extended input field
  function automatic logic [VALUE_WIDTH-1:0] to_store(input logic [FIELD_W-1:0] v);
    logic [63:0] e;
    e = 64'(signed'(v));
    return e[VALUE_WIDTH-1:0];
  endfunction

  // sign-extend a stored value and keep the low field bits
  function automatic logic [FIELD_W-1:0] to_field(input logic [VALUE_WIDTH-1:0] w);
    logic [63:0] e;
    e = 64'(signed'(w));
    return e[FIELD_W-1:0];
  endfunction

  // link an entry holds before it is first written
  function automatic logic [LINK_W-1:0] reset_link(input logic [IDX_W-1:0] idx);
    logic [LINK_W-1:0] l;
    l = LINK_W'(idx) + LINK_W'(1);
    return l;
  endfunction

endpackage

/* hdl/mss_ctrl.sv */
module mss_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic              out_tready,
  input  mss_pkg::dp_stat_t stat,
  output mss_pkg::dp_cmd_t  cmd
);

  mss_pkg::state_t state_r, state_nxt;

  // result register can take a new value this cycle
  logic out_room;
  assign out_room = !stat.out_full || out_tready;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mss_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mss_pkg::S_IDLE: begin
        if (in_tvalid) state_nxt = mss_pkg::S_BUSY;
      end
      mss_pkg::S_BUSY: begin
        if (out_room) state_nxt = mss_pkg::S_IDLE;
      end
      default: state_nxt = mss_pkg::S_IDLE;
    endcase
  end

  // outputs, no transfer taken while reset is held
  always_comb begin
    in_tready  = 1'b0;
    cmd.accept = 1'b0;
    cmd.commit = 1'b0;
    unique case (state_r)
      mss_pkg::S_IDLE: begin
        in_tready  = rst_n;
        cmd.accept = in_tvalid && rst_n;
      end
      mss_pkg::S_BUSY: begin
        cmd.commit = out_room;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

endmodule

/* hdl/mss_datapath.sv */
module mss_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  mss_pkg::dp_cmd_t                    cmd,
  output mss_pkg::dp_stat_t                   stat,
  input  logic                                in_func,
  input  logic [mss_pkg::SIDX_W-1:0]          in_sidx,
  input  logic [mss_pkg::FIELD_W-1:0]         in_value,
  input  logic                                out_tready,
  output logic                                out_valid,
  output mss_pkg::status_t                    out_status,
  output logic [mss_pkg::FIELD_W-1:0]         out_value
);

  // list state
  logic [mss_pkg::LINK_W-1:0]      heads_r [mss_pkg::NUM_STACKS];
  logic [mss_pkg::LINK_W-1:0]      free_head_r;
  logic [mss_pkg::NUM_ENTRIES-1:0] link_vld_r;

  // entry stores
  logic [mss_pkg::VALUE_WIDTH-1:0] value_mem [mss_pkg::NUM_ENTRIES];
  logic [mss_pkg::LINK_W-1:0]      link_mem  [mss_pkg::NUM_ENTRIES];

  // latched request
  logic                            pop_r;
  logic                            fail_r;
  logic [mss_pkg::SIDX_W-1:0]      sidx_r;
  logic [mss_pkg::IDX_W-1:0]       idx_r;
  logic [mss_pkg::VALUE_WIDTH-1:0] val_r;

  // registered reads
  logic [mss_pkg::VALUE_WIDTH-1:0] value_q;
  logic [mss_pkg::LINK_W-1:0]      link_q;
  logic                            link_vld_q;

  // result register
  logic                            out_valid_r;
  mss_pkg::status_t                out_status_r;
  logic [mss_pkg::FIELD_W-1:0]     out_value_r;

  // request decode on the input
  logic                       sidx_bad;
  logic [mss_pkg::LINK_W-1:0] head_sel;
  logic [mss_pkg::LINK_W-1:0] top_sel;
  logic                       fail_now;
  logic [mss_pkg::IDX_W-1:0]  idx_now;

  assign sidx_bad = 32'(in_sidx) >= mss_pkg::NUM_STACKS;
  assign head_sel = sidx_bad ? mss_pkg::NULL_LINK : heads_r[in_sidx];
  assign top_sel  = (in_func == mss_pkg::FUNC_POP) ? head_sel : free_head_r;
  assign fail_now = sidx_bad || (32'(top_sel) >= mss_pkg::NUM_ENTRIES);
  assign idx_now  = top_sel[mss_pkg::IDX_W-1:0];

  // link of the addressed entry, reset pattern until first written
  logic [mss_pkg::LINK_W-1:0] link_rd;
  assign link_rd = link_vld_q ? link_q : mss_pkg::reset_link(idx_r);

  // latch request at the accepted transfer
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pop_r  <= (in_func == mss_pkg::FUNC_POP);
      fail_r <= fail_now;
      sidx_r <= in_sidx;
      idx_r  <= idx_now;
      val_r  <= mss_pkg::to_store(in_value);
    end
  end

  // entry stores: read at accept, write at commit
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      value_q    <= value_mem[idx_now];
      link_q     <= link_mem[idx_now];
      link_vld_q <= link_vld_r[idx_now];
    end
    if (cmd.commit && !fail_r) begin
      link_mem[idx_r] <= pop_r ? free_head_r : heads_r[sidx_r];
      if (!pop_r) value_mem[idx_r] <= val_r;
    end
  end

  // heads, free head and link valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < mss_pkg::NUM_STACKS; i++) heads_r[i] <= mss_pkg::NULL_LINK;
      free_head_r <= '0;
      link_vld_r  <= '0;
    end else if (cmd.commit && !fail_r) begin
      link_vld_r[idx_r] <= 1'b1;
      if (pop_r) begin
        heads_r[sidx_r] <= link_rd;
        free_head_r     <= mss_pkg::LINK_W'(idx_r);
      end else begin
        heads_r[sidx_r] <= mss_pkg::LINK_W'(idx_r);
        free_head_r     <= link_rd;
      end
    end
  end

  // result register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (fail_r) begin
        out_status_r <= pop_r ? mss_pkg::ST_EMPTY : mss_pkg::ST_FULL;
        out_value_r  <= '0;
      end else begin
        out_status_r <= mss_pkg::ST_OK;
        out_value_r  <= pop_r ? mss_pkg::to_field(value_q) : '0;
      end
    end
  end

  assign stat.out_full = out_valid_r;
  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_value     = out_value_r;

endmodule

/* hdl/multi_stack_shared_store.sv */
// channel  direction  handshake            payload
// in       slave      in_tvalid/in_tready  tuser: func, stack_index; tdata: push_value
// out      master     out_tvalid/out_tready tuser: status; tdata: pop_value
//
// each operation has an accept step, which reads the stack or free head
// and starts the entry store read, and a commit step, which writes the links and
// loads the result register; the dependent head-then-link read sets this split.
// reset clears the heads, the free head and the link valid bits at once, no sweep.
// a result waiting in the output register stalls only the commit of the next item.
module multi_stack_shared_store (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [2:0]  in_tuser,   // [0] func, [2:1] stack_index
  input  logic [31:0] in_tdata,   // [31:0] push_value
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [1:0]  out_tuser,  // [1:0] status
  output logic [31:0] out_tdata   // [31:0] pop_value
);

  mss_pkg::dp_cmd_t  cmd;
  mss_pkg::dp_stat_t stat;
  mss_pkg::status_t  out_status;

  // control
  mss_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // lists and stores
  mss_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_func    (in_tuser[0]),
    .in_sidx    (in_tuser[2:1]),
    .in_value   (in_tdata),
    .out_tready (out_tready),
    .out_valid  (out_tvalid),
    .out_status (out_status),
    .out_value  (out_tdata)
  );

  assign out_tuser = out_status;

endmodule
